// ----- hdl/lps_pkg.sv -----
// Shared types and constants for the linear prime sieve core.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

  // Default sizing of the stores
  localparam int DEF_MAX_VALUE   = 65536;
  localparam int DEF_PRIME_SLOTS = 8192;

  // Reset value of the limit register
  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

  // Function codes on the input channel
  localparam logic [1:0] FN_BUILD  = 2'd0;
  localparam logic [1:0] FN_FACTOR = 2'd1;
  localparam logic [1:0] FN_PRIME  = 2'd2;

  // Status codes on the output channel
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_BUILT = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SREAD,
    S_STEST,
    S_JREAD,
    S_JMUL,
    S_JCHK,
    S_INEXT,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // input item taken this cycle
    logic build_init;  // clear prime count, start index at two
    logic done_build;  // mark the sieve as built
    logic clr_wr;      // zero the factor entry at the index
    logic i_adv;       // advance the outer index
    logic i_reset;     // restart the outer index at two
    logic s_read;      // read the factor entry at the index
    logic s_test;      // test that entry, record a new prime
    logic j_read;      // read the next listed prime
    logic j_mul;       // form prime times index
    logic j_chk;       // mark the product, advance the inner index
    logic out_load;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic func_build;  // input item is a build command
    logic lim_small;   // effective limit below two
    logic i_last;      // outer index at the limit
    logic j_end;       // inner index reached the prime count
    logic prod_over;   // product above the limit
    logic p_is_spf;    // prime equals smallest factor of the index
    logic out_free;    // result register empty or draining
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/lps_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; used by the datapath for the factor store and the prime list.
`timescale 1ns / 1ps
`default_nettype none

module lps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/lps_ctrl.sv -----
// Controller state machine of the linear prime sieve core.
// Depends on lps_pkg for the state type and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module lps_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lps_pkg::sts_t sts,
  output lps_pkg::cmd_t cmd
);

  lps_pkg::state_t state;
  lps_pkg::state_t state_next;
  logic            take;

  assign take = (state == lps_pkg::S_IDLE) && in_valid && sts.out_free;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lps_pkg::S_IDLE: begin
        if (take) begin
          if (sts.func_build && !sts.lim_small) begin
            state_next = lps_pkg::S_CLEAR;
          end else begin
            state_next = lps_pkg::S_RESP;
          end
        end
      end
      lps_pkg::S_CLEAR: begin
        if (sts.i_last) begin
          state_next = lps_pkg::S_SREAD;
        end
      end
      lps_pkg::S_SREAD: state_next = lps_pkg::S_STEST;
      lps_pkg::S_STEST: state_next = lps_pkg::S_JREAD;
      lps_pkg::S_JREAD: begin
        if (sts.j_end) begin
          state_next = lps_pkg::S_INEXT;
        end else begin
          state_next = lps_pkg::S_JMUL;
        end
      end
      lps_pkg::S_JMUL: state_next = lps_pkg::S_JCHK;
      lps_pkg::S_JCHK: begin
        if (sts.prod_over || sts.p_is_spf) begin
          state_next = lps_pkg::S_INEXT;
        end else begin
          state_next = lps_pkg::S_JREAD;
        end
      end
      lps_pkg::S_INEXT: begin
        if (sts.i_last) begin
          state_next = lps_pkg::S_RESP;
        end else begin
          state_next = lps_pkg::S_SREAD;
        end
      end
      lps_pkg::S_RESP: state_next = lps_pkg::S_IDLE;
      default: state_next = lps_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      lps_pkg::S_IDLE: begin
        in_ready       = sts.out_free;
        cmd.accept     = take;
        cmd.build_init = take && sts.func_build;
        cmd.done_build = take && sts.func_build && sts.lim_small;
      end
      lps_pkg::S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.i_adv   = !sts.i_last;
        cmd.i_reset = sts.i_last;
      end
      lps_pkg::S_SREAD: cmd.s_read = 1'b1;
      lps_pkg::S_STEST: cmd.s_test = 1'b1;
      lps_pkg::S_JREAD: cmd.j_read = !sts.j_end;
      lps_pkg::S_JMUL:  cmd.j_mul  = 1'b1;
      lps_pkg::S_JCHK:  cmd.j_chk  = !sts.prod_over;
      lps_pkg::S_INEXT: begin
        cmd.i_adv      = !sts.i_last;
        cmd.done_build = sts.i_last;
      end
      lps_pkg::S_RESP: cmd.out_load = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/lps_datapath.sv -----
// Datapath of the linear prime sieve core: limit register, factor store,
// prime list, sieve indices, multiplier and result register.
// Depends on lps_pkg and lps_ram.
`timescale 1ns / 1ps
`default_nettype none

module lps_datapath #(
  parameter int MAX_VALUE   = lps_pkg::DEF_MAX_VALUE,
  parameter int PRIME_SLOTS = lps_pkg::DEF_PRIME_SLOTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    func,
  input  logic [15:0]   operand,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   value,
  output logic          is_prime,
  output logic [1:0]    status,
  input  lps_pkg::cmd_t cmd,
  output lps_pkg::sts_t sts
);

  // Values never exceed 16 bits, so the factor store stops at 65536 entries
  localparam int SPF_DEPTH = (MAX_VALUE < 65536) ? MAX_VALUE : 65536;
  localparam int VW        = $clog2(SPF_DEPTH);
  localparam int TOP       = SPF_DEPTH - 1;
  localparam int PL_AW     = $clog2(PRIME_SLOTS);
  localparam int CW        = $clog2(PRIME_SLOTS + 1);
  localparam int PW        = 2 * VW;

  logic [15:0]       limit;
  logic              built;
  logic [CW-1:0]     count;
  logic [CW-1:0]     j;
  logic [VW-1:0]     i;
  logic [VW-1:0]     p;
  logic [VW-1:0]     spf_i;
  logic [PW-1:0]     prod;
  logic [1:0]        func_q;
  logic [1:0]        err_q;
  logic [VW-1:0]     opnd_q;
  logic [VW-1:0]     lim;
  logic [1:0]        err;
  logic [15:0]       op_m1;
  logic              new_prime;

  logic              spf_we;
  logic [VW-1:0]     spf_waddr;
  logic [VW-1:0]     spf_wdata;
  logic [VW-1:0]     spf_raddr;
  logic [VW-1:0]     spf_rdata;
  logic              pl_we;
  logic [PL_AW-1:0]  pl_waddr;
  logic [PL_AW-1:0]  pl_raddr;
  logic [VW-1:0]     pl_rdata;

  logic [15:0]       value_next;
  logic              is_prime_next;
  logic [1:0]        status_next;

  assign cfg_ready = 1'b1;

  // Effective limit
  assign lim = (32'(limit) < TOP) ? VW'(limit) : VW'(TOP);

  // Status toward the controller
  assign sts.func_build = (func == lps_pkg::FN_BUILD);
  assign sts.lim_small  = (lim < VW'(2));
  assign sts.i_last     = (i == lim);
  assign sts.j_end      = (j == count);
  assign sts.prod_over  = (prod > PW'(lim));
  assign sts.p_is_spf   = (p == spf_i);
  assign sts.out_free   = !out_valid || out_ready;

  // Classify the incoming item
  always_comb begin
    err = lps_pkg::STAT_OK;
    case (func)
      lps_pkg::FN_BUILD: err = lps_pkg::STAT_OK;
      lps_pkg::FN_FACTOR: begin
        if (!built) begin
          err = lps_pkg::STAT_NOT_BUILT;
        end else if (operand < 16'd2 || 32'(operand) > 32'(lim)) begin
          err = lps_pkg::STAT_RANGE;
        end
      end
      lps_pkg::FN_PRIME: begin
        if (!built) begin
          err = lps_pkg::STAT_NOT_BUILT;
        end else if (operand == 16'd0 || 32'(operand) > 32'(count)) begin
          err = lps_pkg::STAT_RANGE;
        end
      end
      default: err = lps_pkg::STAT_RANGE;
    endcase
  end

  // Store ports: queries read at the operand while idle
  assign op_m1     = operand - 16'd1;
  assign new_prime = cmd.s_test && (spf_rdata == '0);
  assign spf_we    = cmd.clr_wr || new_prime || cmd.j_chk;
  assign spf_waddr = cmd.j_chk ? prod[VW-1:0] : i;
  assign spf_wdata = cmd.j_chk ? p : (cmd.clr_wr ? '0 : i);
  assign spf_raddr = cmd.s_read ? i : operand[VW-1:0];
  assign pl_we     = new_prime && (32'(count) < PRIME_SLOTS);
  assign pl_waddr  = PL_AW'(count);
  assign pl_raddr  = cmd.j_read ? PL_AW'(j) : PL_AW'(op_m1);

  lps_ram #(
    .WIDTH (VW),
    .DEPTH (SPF_DEPTH)
  ) u_spf_ram (
    .clk   (clk),
    .we    (spf_we),
    .waddr (spf_waddr),
    .wdata (spf_wdata),
    .raddr (spf_raddr),
    .rdata (spf_rdata)
  );

  lps_ram #(
    .WIDTH (VW),
    .DEPTH (PRIME_SLOTS)
  ) u_prime_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (i),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  // Control registers: limit, built flag, counts, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= lps_pkg::LIMIT_RESET;
      built     <= 1'b0;
      count     <= '0;
      j         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
        built <= 1'b0;
      end else if (cmd.done_build) begin
        built <= 1'b1;
      end
      if (cmd.build_init) begin
        count <= '0;
        j     <= '0;
      end else begin
        if (pl_we) begin
          count <= count + CW'(1);
        end
        if (cmd.s_test) begin
          j <= '0;
        end else if (cmd.j_chk) begin
          j <= j + CW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sieve payload registers and latched query
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q <= func;
      err_q  <= err;
      opnd_q <= operand[VW-1:0];
    end
    if (cmd.build_init || cmd.i_reset) begin
      i <= VW'(2);
    end else if (cmd.i_adv) begin
      i <= i + VW'(1);
    end
    if (cmd.s_test) begin
      spf_i <= new_prime ? i : spf_rdata;
    end
    if (cmd.j_mul) begin
      p    <= pl_rdata;
      prod <= PW'(pl_rdata) * PW'(i);
    end
  end

  // Build the result from the latched query and the read data
  always_comb begin
    value_next    = '0;
    is_prime_next = 1'b0;
    status_next   = err_q;
    case (func_q)
      lps_pkg::FN_BUILD: begin
        value_next  = 16'(count);
        status_next = lps_pkg::STAT_OK;
      end
      lps_pkg::FN_FACTOR: begin
        if (err_q == lps_pkg::STAT_OK) begin
          value_next    = 16'(spf_rdata);
          is_prime_next = (spf_rdata == opnd_q);
        end
      end
      lps_pkg::FN_PRIME: begin
        if (err_q == lps_pkg::STAT_OK) begin
          value_next = 16'(pl_rdata);
        end
      end
      default: value_next = '0;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value    <= value_next;
      is_prime <= is_prime_next;
      status   <= status_next;
    end
  end

  // The prime count never passes the list size
  assert property (@(posedge clk) disable iff (rst) 32'(count) <= PRIME_SLOTS)
    else $error("prime count beyond list size");

  // The inner index never runs past the prime count
  assert property (@(posedge clk) disable iff (rst) 32'(j) <= 32'(count))
    else $error("inner index beyond prime count");

  // Factor store writes stay inside the sieve range
  assert property (@(posedge clk) disable iff (rst)
    spf_we |-> 32'(spf_waddr) <= 32'(lim))
    else $error("factor store write above limit");

  // A build result is only given once the sieve is marked built
  assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && func_q == lps_pkg::FN_BUILD) |-> built)
    else $error("build result without built flag");

endmodule

`default_nettype wire

// ----- hdl/linear_prime_sieve_core.sv -----
// Linear (Euler) prime sieve with smallest-prime-factor store.
//
// Channels: input items (func, operand) on in_valid/in_ready, results
// (value, is_prime, status) on out_valid/out_ready, and the limit register on
// cfg_valid/cfg_ready/cfg_data. Write the limit only while the block is idle;
// a write clears the built flag, so a new build is needed.
// Queries: a factor or k-th prime query reads one store; the item is latched
// on acceptance and the result register is loaded in S_RESP, and no new item
// is taken until the block is back in S_IDLE. Error results take the same path.
// Build: zeroes factor entries 2..L (L the effective limit), then sieves each
// index: read its factor entry, test it and list a new prime, then for each
// listed prime read it, form the product with the registered multiply and mark
// the product, stopping when the product passes the limit, the prime equals the
// smallest factor of the index, or the walk reaches the count.
// in_ready stays low for the whole build; a limit below two builds at once.
// Reset: clears state and flags; there is no clearing pass after reset, as
// the build sweeps the store itself. A stalled receiver holds the result
// register, and no new item is accepted until that result is taken.
// Depends on lps_pkg, lps_ctrl, lps_datapath and lps_ram.
`timescale 1ns / 1ps
`default_nettype none

module linear_prime_sieve_core #(
  parameter int MAX_VALUE   = lps_pkg::DEF_MAX_VALUE,
  parameter int PRIME_SLOTS = lps_pkg::DEF_PRIME_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [15:0] operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] value,
  output logic        is_prime,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  lps_pkg::cmd_t cmd;
  lps_pkg::sts_t sts;

  // Sequencer
  lps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stores, indices and result register
  lps_datapath #(
    .MAX_VALUE   (MAX_VALUE),
    .PRIME_SLOTS (PRIME_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .operand   (operand),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .is_prime  (is_prime),
    .status    (status),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ----- tb/tb_linear_prime_sieve_core.sv -----
// Self-checking testbench for linear_prime_sieve_core: a scoreboard class sieves
// alongside the block and checks every result in order.
// Depends on lps_pkg and the RTL of linear_prime_sieve_core.
`timescale 1ns / 1ps

// Function code with no operation behind it
localparam logic [1:0] FN_SPARE = 2'd3;

typedef struct packed {
  logic [15:0] value;
  logic        is_prime;
  logic [1:0]  status;
} sieve_result_t;

class sieve_scoreboard;
  logic [15:0]   limit_q;
  bit            sieved;
  int            n_primes;
  logic [15:0]   spf_tab [lps_pkg::DEF_MAX_VALUE];
  logic [15:0]   primes [lps_pkg::DEF_PRIME_SLOTS];
  sieve_result_t due_results [$];

  int mismatches;
  int n_checked;
  int n_builds;
  int n_factor;
  int n_prime;
  int n_spare;
  int n_errors;
  int n_limits;

  function new();
    foreach (spf_tab[n]) spf_tab[n] = '0;
    foreach (primes[n]) primes[n] = '0;
    limit_q  = lps_pkg::LIMIT_RESET;
    sieved   = 1'b0;
    n_primes = 0;
  endfunction

  // Clamp the limit to the top of the factor store
  function int top_value();
    return (int'(limit_q) < lps_pkg::DEF_MAX_VALUE - 1) ? int'(limit_q)
                                                         : lps_pkg::DEF_MAX_VALUE - 1;
  endfunction

  // Mark each composite once, by its smallest prime factor
  function void sieve_to_limit();
    int     top;
    int     i;
    int     j;
    longint prod;
    top = top_value();
    foreach (spf_tab[n]) spf_tab[n] = '0;
    n_primes = 0;
    for (i = 2; i <= top; i++) begin
      if (spf_tab[i] == 16'd0) begin
        spf_tab[i] = 16'(i);
        if (n_primes < lps_pkg::DEF_PRIME_SLOTS) begin
          primes[n_primes] = 16'(i);
          n_primes++;
        end
      end
      for (j = 0; j < n_primes; j++) begin
        prod = longint'(primes[j]) * longint'(i);
        if (prod > top) break;
        spf_tab[int'(prod)] = primes[j];
        if (primes[j] == spf_tab[i]) break;
      end
    end
    sieved = 1'b1;
  endfunction

  function void note_limit(logic [15:0] v);
    limit_q = v;
    sieved  = 1'b0;
    n_limits++;
  endfunction

  // Work out the result of an accepted item and queue it
  function void note_item(logic [1:0] f, logic [15:0] op);
    sieve_result_t r;
    r = '0;
    if (f == lps_pkg::FN_BUILD) begin
      sieve_to_limit();
      r.value = n_primes[15:0];
      n_builds++;
    end else if (f == FN_SPARE) begin
      r.status = lps_pkg::STAT_RANGE;
      n_spare++;
    end else if (!sieved) begin
      r.status = lps_pkg::STAT_NOT_BUILT;
    end else if (f == lps_pkg::FN_FACTOR) begin
      if (op < 16'd2 || int'(op) > top_value()) begin
        r.status = lps_pkg::STAT_RANGE;
      end else begin
        r.value    = spf_tab[op];
        r.is_prime = (spf_tab[op] == op);
      end
    end else begin
      if (op == 16'd0 || int'(op) > n_primes) r.status = lps_pkg::STAT_RANGE;
      else r.value = primes[op - 16'd1];
    end
    if (f == lps_pkg::FN_FACTOR) n_factor++;
    if (f == lps_pkg::FN_PRIME) n_prime++;
    if (r.status != lps_pkg::STAT_OK) n_errors++;
    due_results.push_back(r);
  endfunction

  // Print one line per mismatch and count it
  task report(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    $display("ERROR at result %0d: %s is %0d, %0d due", n_checked, what, got, want);
  endtask

  task check_result(logic [15:0] v, logic p, logic [1:0] s);
    sieve_result_t want;
    n_checked++;
    if (due_results.size() == 0) begin
      report("unasked result, value", v, 16'd0);
    end else begin
      want = due_results.pop_front();
      if (v !== want.value) report("value", v, want.value);
      if (p !== want.is_prime) report("is_prime", 16'(p), 16'(want.is_prime));
      if (s !== want.status) report("status", 16'(s), 16'(want.status));
    end
  endtask

  task flush_leftover();
    sieve_result_t want;
    while (due_results.size() != 0) begin
      want = due_results.pop_front();
      report("missing result, value", 16'd0, want.value);
    end
  endtask
endclass

module tb_linear_prime_sieve_core;
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [15:0] operand;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] value;
  logic        is_prime;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  sieve_scoreboard sb;
  bit hold_req = 1'b0;
  int burst_left = 0;

  linear_prime_sieve_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .operand   (operand),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .is_prime  (is_prime),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Offer one item and hold it until the block takes it
  task automatic push_item(input logic [1:0] f, input logic [15:0] op);
    in_valid <= 1'b1;
    func     <= f;
    operand  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(f, op);
  endtask

  // Send in bursts, dropping valid for a random gap between them
  task automatic feed(input logic [1:0] f, input logic [15:0] op);
    int gap;
    push_item(f, op);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_limit(v);
    cfg_valid <= 1'b0;
  endtask

  // One limit setting: mostly build then query in range, plus some noise
  task automatic random_phase(input int n_items);
    logic [15:0] lim;
    logic [1:0]  f;
    logic [15:0] op;
    int          pick;
    int          k;
    lim = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(300, 2000))
                                      : 16'($urandom_range(2, 300));
    drain();
    write_limit(lim);
    if ($urandom_range(0, 4) != 0) feed(lps_pkg::FN_BUILD, 16'($urandom));
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        f  = lps_pkg::FN_BUILD;
        op = 16'($urandom);
      end else if (pick < 8) begin
        f  = FN_SPARE;
        op = 16'($urandom);
      end else if (pick < 16) begin
        f  = 2'($urandom_range(1, 2));
        op = 16'($urandom);
      end else if (pick < 58) begin
        f  = lps_pkg::FN_FACTOR;
        op = 16'($urandom_range(0, int'(lim) + 2));
      end else begin
        f  = lps_pkg::FN_PRIME;
        op = 16'($urandom_range(0, sb.n_primes + 2));
      end
      feed(f, op);
    end
  endtask

  // Receiver: random stall modes, plus a long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 600;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Check each result as it is taken
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(value, is_prime, status);
  end

  // Stimulus
  initial begin
    int k;
    int pick;
    int waited;
    sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    func      <= lps_pkg::FN_BUILD;
    operand   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Queries before any build, and the unused code
    feed(lps_pkg::FN_FACTOR, 16'd100);
    feed(lps_pkg::FN_PRIME, 16'd1);
    feed(FN_SPARE, 16'd0);

    // Limit of zero: empty sieve, every query out of range
    drain();
    write_limit(16'd0);
    feed(lps_pkg::FN_BUILD, 16'hFFFF);
    feed(lps_pkg::FN_FACTOR, 16'd0);
    feed(lps_pkg::FN_PRIME, 16'd1);
    feed(FN_SPARE, 16'hFFFF);

    // Smallest useful limit; the write clears the built flag
    drain();
    write_limit(16'd2);
    feed(lps_pkg::FN_FACTOR, 16'd2);
    feed(lps_pkg::FN_BUILD, 16'd0);
    feed(lps_pkg::FN_FACTOR, 16'd2);
    feed(lps_pkg::FN_FACTOR, 16'd1);
    feed(lps_pkg::FN_FACTOR, 16'd3);
    feed(lps_pkg::FN_PRIME, 16'd0);
    feed(lps_pkg::FN_PRIME, 16'd1);
    feed(lps_pkg::FN_PRIME, 16'd2);

    // Full range, built once
    drain();
    write_limit(16'hFFFF);
    feed(lps_pkg::FN_BUILD, 16'd0);
    feed(lps_pkg::FN_FACTOR, 16'hFFFF);
    feed(lps_pkg::FN_FACTOR, 16'd65521);
    feed(lps_pkg::FN_FACTOR, 16'd4);
    feed(lps_pkg::FN_FACTOR, 16'd0);
    feed(lps_pkg::FN_PRIME, 16'd6542);
    feed(lps_pkg::FN_PRIME, 16'd6543);
    feed(lps_pkg::FN_PRIME, 16'hFFFF);
    feed(FN_SPARE, 16'hFFFF);

    // Random queries over the full range, no further builds
    for (k = 0; k < 400; k++) begin
      if (k == 100) hold_req = 1'b1;
      if (k == 250) drain();
      pick = $urandom_range(0, 99);
      if (pick < 5) feed(FN_SPARE, 16'($urandom));
      else if (pick < 45) feed(lps_pkg::FN_FACTOR, 16'($urandom));
      else if (pick < 85) feed(lps_pkg::FN_PRIME, 16'($urandom_range(0, 6545)));
      else feed(lps_pkg::FN_PRIME, 16'($urandom));
    end

    // Many smaller limits with builds mixed in
    for (k = 0; k < 14; k++) random_phase(52);

    // Wait for the last results, then a few idle cycles
    in_valid <= 1'b0;
    waited = 0;
    while (sb.due_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    sb.flush_leftover();

    $display("Run covered %0d results: %0d builds, %0d factor and %0d prime queries,",
             sb.n_checked, sb.n_builds, sb.n_factor, sb.n_prime);
    $display("%0d unused codes; error results due: %0d; limit settings written: %0d.",
             sb.n_spare, sb.n_errors, sb.n_limits);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20000000;
    $display("Run timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lps_pkg.sv
hdl/lps_ram.sv
hdl/lps_ctrl.sv
hdl/lps_datapath.sv
hdl/linear_prime_sieve_core.sv
tb/tb_linear_prime_sieve_core.sv
